@@ hw/rtl/lbcs_pkg.sv @@
`timescale 1ns / 1ps
package lbcs_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int DEVICES_DEF = 16;

	localparam int ACT_W  = 3;
	localparam int DEV_W  = 4;
	localparam int BLK_W  = 16;
	localparam int SEQ_W  = 32;
	localparam int WANT_W = 5;
	localparam int PIN_W  = 8;
	localparam int ST_W   = 3;
	localparam int SLOT_W = 4;

	localparam logic [ACT_W-1:0] ACT_LOOKUP    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FREE      = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INVAL     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FLUSH_DEV = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FLUSH_ALL = 3'd4;
	localparam logic [ACT_W-1:0] ACT_COUNT     = 3'd5;
	localparam logic [ACT_W-1:0] ACT_UPDATE    = 3'd6;
	localparam logic [ACT_W-1:0] ACT_UNUSED    = 3'd7;

	localparam logic [ST_W-1:0] ST_HIT       = 3'd0;
	localparam logic [ST_W-1:0] ST_MISS      = 3'd1;
	localparam logic [ST_W-1:0] ST_NO_SLOT   = 3'd2;
	localparam logic [ST_W-1:0] ST_WRITEBACK = 3'd3;
	localparam logic [ST_W-1:0] ST_DONE      = 3'd4;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd5;

endpackage

@@ hw/rtl/lbcs_if.sv @@
`timescale 1ns / 1ps
interface lbcs_req_if;
	logic                            valid;
	logic                            ready;
	logic [lbcs_pkg::ACT_W-1:0]      action;
	logic [lbcs_pkg::DEV_W-1:0]      device;
	logic [lbcs_pkg::BLK_W-1:0]      block_id;
	logic [lbcs_pkg::SEQ_W-1:0]      committed_seq;
	logic [lbcs_pkg::WANT_W-1:0]     want;
	logic                            set_dirty;
	logic                            set_logged;
	logic [lbcs_pkg::SEQ_W-1:0]      log_seq;
	logic signed [1:0]               pin_change;

	modport source(output valid, action, device, block_id, committed_seq, want, set_dirty,
		set_logged, log_seq, pin_change, input ready);
	modport sink(input valid, action, device, block_id, committed_seq, want, set_dirty,
		set_logged, log_seq, pin_change, output ready);
endinterface

interface lbcs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lbcs_pkg::ST_W-1:0]     status;
	logic [lbcs_pkg::SLOT_W-1:0]   slot;
	logic [lbcs_pkg::DEV_W-1:0]    entry_device;
	logic [lbcs_pkg::BLK_W-1:0]    entry_block;
	logic                          enough;
	logic                          last;

	modport source(output valid, status, slot, entry_device, entry_block, enough, last,
		input ready);
	modport sink(input valid, status, slot, entry_device, entry_block, enough, last,
		output ready);
endinterface

@@ hw/rtl/lru_buffer_cache_slots_unit.sv @@
`timescale 1ns / 1ps
// LRU slot manager for a block cache of ENTRIES slots. One request is taken at a time: ready
// is high only while the block is idle, and results leave through a one-deep output register.
// The work is done by a sequencer that visits one slot per cycle with one shared wraparound
// sequence compare, and it waits while the output register cannot take a result. Lookup, free
// and update search the slots for the key, and a lookup miss then walks the LRU order; count
// walks the LRU order; invalidate and flush find each entry of the device (of every device for
// flush-all) in key order by a full scan. Each result also needs the output register to be free.
module lru_buffer_cache_slots_unit #(
	parameter int ENTRIES = lbcs_pkg::ENTRIES_DEF,
	parameter int DEVICES = lbcs_pkg::DEVICES_DEF
) (
	input logic clk,
	input logic arst_n,
	lbcs_req_if.sink   req,
	lbcs_rsp_if.source rsp
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SW = (IW > lbcs_pkg::SLOT_W) ? IW : lbcs_pkg::SLOT_W;
	localparam int KW = lbcs_pkg::DEV_W + lbcs_pkg::BLK_W;
	localparam logic [8:0] DEV_LIM = 9'(DEVICES);
	localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_FIND  = 9'b000000010,
		S_ACT   = 9'b000000100,
		S_LRU   = 9'b000001000,
		S_WB    = 9'b000010000,
		S_ALLOC = 9'b000100000,
		S_MIN   = 9'b001000000,
		S_FACT  = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	function automatic logic [lbcs_pkg::SLOT_W-1:0] slot4(input logic [IW-1:0] s);
		logic [SW-1:0] e;
		e = SW'(s);
		return e[lbcs_pkg::SLOT_W-1:0];
	endfunction

	logic                          valid_q  [ENTRIES];
	logic [lbcs_pkg::DEV_W-1:0]    dev_q    [ENTRIES];
	logic [lbcs_pkg::BLK_W-1:0]    blk_q    [ENTRIES];
	logic                          dirty_q  [ENTRIES];
	logic                          logged_q [ENTRIES];
	logic [lbcs_pkg::SEQ_W-1:0]    seq_q    [ENTRIES];
	logic [lbcs_pkg::PIN_W-1:0]    pins_q   [ENTRIES];
	logic [IW-1:0]                 order_q  [ENTRIES];
	logic [ENTRIES-1:0]            seen_q;

	state_t                        state_q, state_d;
	logic [lbcs_pkg::ACT_W-1:0]    act_q;
	logic [lbcs_pkg::DEV_W-1:0]    rdev_q;
	logic [lbcs_pkg::BLK_W-1:0]    rblk_q;
	logic [lbcs_pkg::SEQ_W-1:0]    com_q;
	logic [lbcs_pkg::WANT_W-1:0]   n_q;
	logic                          sd_q, sl_q, bad_q, found_q, bfound_q;
	logic [lbcs_pkg::SEQ_W-1:0]    lseq_q;
	logic [1:0]                    pc_q;
	logic [IW-1:0]                 idx_q, hit_q, best_q;
	logic [KW-1:0]                 bkey_q;

	logic                          ov_q;
	logic [lbcs_pkg::ST_W-1:0]     ost_q;
	logic [lbcs_pkg::SLOT_W-1:0]   oslot_q;
	logic [lbcs_pkg::DEV_W-1:0]    odev_q;
	logic [lbcs_pkg::BLK_W-1:0]    oblk_q;
	logic                          oen_q, olast_q;

	logic                          acc, can_emit, em, em_en, em_last;
	logic [lbcs_pkg::ST_W-1:0]     em_st;
	logic [lbcs_pkg::SLOT_W-1:0]   em_slot;
	logic [lbcs_pkg::DEV_W-1:0]    em_dev;
	logic [lbcs_pkg::BLK_W-1:0]    em_blk;
	logic                          op_back, op_front, op_alloc, op_upd, op_wbclr, op_seen;
	logic                          idx_inc, idx_clr, hit_ld, n_dec;
	logic [IW-1:0]                 hit_d, sel_s, lru_s, pos;
	logic                          seq_le, evict, cand, last_idx, match;
	logic                          elig, take, nb_found;
	logic [IW-1:0]                 nb_idx;
	logic [KW-1:0]                 ikey;
	logic [9:0]                    psum;
	logic [lbcs_pkg::PIN_W-1:0]    pnew;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign can_emit  = !ov_q || rsp.ready;
	assign last_idx  = (idx_q == IDX_LAST);
	assign lru_s     = order_q[idx_q];
	assign sel_s     = (state_q == S_LRU) ? lru_s : hit_q;

	lbcs_seq_unit u_seq (
		.a (seq_q[sel_s]),
		.b (com_q),
		.le(seq_le)
	);

	assign evict = (pins_q[sel_s] == '0) && (!logged_q[sel_s] || seq_le);
	assign cand  = !valid_q[sel_s] || evict;
	assign match = valid_q[idx_q] && (dev_q[idx_q] == rdev_q) && (blk_q[idx_q] == rblk_q);

	assign ikey     = {dev_q[idx_q], blk_q[idx_q]};
	assign elig     = valid_q[idx_q] && !seen_q[idx_q] &&
		((act_q == lbcs_pkg::ACT_FLUSH_ALL) || (dev_q[idx_q] == rdev_q));
	assign take     = elig && (!bfound_q || (ikey < bkey_q));
	assign nb_found = bfound_q || take;
	assign nb_idx   = take ? idx_q : best_q;

	assign psum = {2'b00, pins_q[hit_q]} + {{8{pc_q[1]}}, pc_q};
	assign pnew = psum[9] ? '0 : (psum[8] ? '1 : psum[7:0]);

	always_comb begin
		pos = '0;
		for (int p = ENTRIES - 1; p >= 0; p--) begin
			if (order_q[p] == hit_q) begin
				pos = IW'(p);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		em       = 1'b0;
		em_st    = lbcs_pkg::ST_DONE;
		em_slot  = '0;
		em_dev   = rdev_q;
		em_blk   = rblk_q;
		em_en    = 1'b0;
		em_last  = 1'b1;
		op_back  = 1'b0;
		op_front = 1'b0;
		op_alloc = 1'b0;
		op_upd   = 1'b0;
		op_wbclr = 1'b0;
		op_seen  = 1'b0;
		idx_inc  = 1'b0;
		idx_clr  = 1'b0;
		hit_ld   = 1'b0;
		hit_d    = hit_q;
		n_dec    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					idx_clr = 1'b1;
					case (req.action)
						lbcs_pkg::ACT_LOOKUP: begin
							state_d = ({5'd0, req.device} >= DEV_LIM) ? S_ACT : S_FIND;
						end
						lbcs_pkg::ACT_FREE, lbcs_pkg::ACT_UPDATE: state_d = S_FIND;
						lbcs_pkg::ACT_INVAL, lbcs_pkg::ACT_FLUSH_DEV,
						lbcs_pkg::ACT_FLUSH_ALL: state_d = S_MIN;
						lbcs_pkg::ACT_COUNT: state_d = S_LRU;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_FIND: begin
				if (match) begin
					hit_ld  = 1'b1;
					hit_d   = idx_q;
					state_d = S_ACT;
				end else if (last_idx) begin
					state_d = S_ACT;
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_ACT: begin
				if (act_q == lbcs_pkg::ACT_LOOKUP && !bad_q && !found_q) begin
					idx_clr = 1'b1;
					state_d = S_LRU;
				end else if (can_emit) begin
					em      = 1'b1;
					state_d = S_IDLE;
					if (act_q == lbcs_pkg::ACT_LOOKUP) begin
						if (bad_q) begin
							em_st = lbcs_pkg::ST_NO_SLOT;
						end else begin
							em_st   = lbcs_pkg::ST_HIT;
							em_slot = slot4(hit_q);
							op_back = 1'b1;
						end
					end else if (!found_q) begin
						em_st = lbcs_pkg::ST_NOT_FOUND;
					end else begin
						em_slot  = slot4(hit_q);
						op_front = (act_q == lbcs_pkg::ACT_FREE);
						op_upd   = (act_q == lbcs_pkg::ACT_UPDATE);
					end
				end
			end
			S_LRU: begin
				if (act_q == lbcs_pkg::ACT_COUNT) begin
					if (n_q == '0) begin
						state_d = S_FIN;
					end else begin
						n_dec = cand;
						if (last_idx) begin
							state_d = S_FIN;
						end else begin
							idx_inc = 1'b1;
						end
					end
				end else if (cand) begin
					hit_ld  = 1'b1;
					hit_d   = lru_s;
					state_d = (valid_q[lru_s] && dirty_q[lru_s]) ? S_WB : S_ALLOC;
				end else if (last_idx) begin
					if (can_emit) begin
						em      = 1'b1;
						em_st   = lbcs_pkg::ST_NO_SLOT;
						state_d = S_IDLE;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_WB: begin
				if (can_emit) begin
					em      = 1'b1;
					em_st   = lbcs_pkg::ST_WRITEBACK;
					em_slot = slot4(hit_q);
					em_dev  = dev_q[hit_q];
					em_blk  = blk_q[hit_q];
					em_last = 1'b0;
					state_d = S_ALLOC;
				end
			end
			S_ALLOC: begin
				if (can_emit) begin
					em       = 1'b1;
					em_st    = lbcs_pkg::ST_MISS;
					em_slot  = slot4(hit_q);
					op_alloc = 1'b1;
					op_back  = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_MIN: begin
				if (last_idx) begin
					hit_ld  = 1'b1;
					hit_d   = nb_idx;
					state_d = nb_found ? S_FACT : S_FIN;
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_FACT: begin
				if (act_q == lbcs_pkg::ACT_INVAL) begin
					op_front = 1'b1;
					op_seen  = 1'b1;
					idx_clr  = 1'b1;
					state_d  = S_MIN;
				end else if (dirty_q[hit_q] && (!logged_q[hit_q] || seq_le)) begin
					if (can_emit) begin
						em       = 1'b1;
						em_st    = lbcs_pkg::ST_WRITEBACK;
						em_slot  = slot4(hit_q);
						em_dev   = dev_q[hit_q];
						em_blk   = blk_q[hit_q];
						em_last  = 1'b0;
						op_wbclr = 1'b1;
						op_seen  = 1'b1;
						idx_clr  = 1'b1;
						state_d  = S_MIN;
					end
				end else begin
					op_seen = 1'b1;
					idx_clr = 1'b1;
					state_d = S_MIN;
				end
			end
			S_FIN: begin
				if (can_emit) begin
					em      = 1'b1;
					em_blk  = '0;
					em_dev  = (act_q == lbcs_pkg::ACT_FLUSH_ALL) ? '0 : rdev_q;
					em_en   = (act_q == lbcs_pkg::ACT_COUNT) && (n_q == '0);
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			hit_q    <= '0;
			best_q   <= '0;
			bkey_q   <= '0;
			bfound_q <= 1'b0;
			found_q  <= 1'b0;
			bad_q    <= 1'b0;
			n_q      <= '0;
			seen_q   <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (idx_clr) begin
				idx_q    <= '0;
				bfound_q <= 1'b0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == S_MIN && take && !last_idx) begin
				best_q   <= idx_q;
				bkey_q   <= ikey;
				bfound_q <= 1'b1;
			end
			if (hit_ld) begin
				hit_q <= hit_d;
			end
			if (state_q == S_FIND) begin
				found_q <= match;
			end
			if (n_dec) begin
				n_q <= n_q - 1'b1;
			end
			if (op_seen) begin
				seen_q[hit_q] <= 1'b1;
			end
			if (acc) begin
				bad_q  <= ({5'd0, req.device} >= DEV_LIM);
				n_q    <= req.want;
				seen_q <= '0;
			end
			if (em) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q  <= req.action;
			rdev_q <= req.device;
			rblk_q <= req.block_id;
			com_q  <= req.committed_seq;
			sd_q   <= req.set_dirty;
			sl_q   <= req.set_logged;
			lseq_q <= req.log_seq;
			pc_q   <= req.pin_change;
		end
		if (em) begin
			ost_q   <= em_st;
			oslot_q <= em_slot;
			odev_q  <= em_dev;
			oblk_q  <= em_blk;
			oen_q   <= em_en;
			olast_q <= em_last;
		end
		if (op_upd) begin
			seq_q[hit_q] <= lseq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < ENTRIES; p++) begin
				valid_q[p]  <= 1'b0;
				dev_q[p]    <= '0;
				blk_q[p]    <= '0;
				dirty_q[p]  <= 1'b0;
				logged_q[p] <= 1'b0;
				pins_q[p]   <= '0;
				order_q[p]  <= IW'(p);
			end
		end else begin
			if (op_alloc) begin
				valid_q[hit_q]  <= 1'b1;
				dirty_q[hit_q]  <= 1'b0;
				logged_q[hit_q] <= 1'b0;
				dev_q[hit_q]    <= rdev_q;
				blk_q[hit_q]    <= rblk_q;
			end
			if (op_front) begin
				valid_q[hit_q]  <= 1'b0;
				dirty_q[hit_q]  <= 1'b0;
				logged_q[hit_q] <= 1'b0;
				dev_q[hit_q]    <= '0;
				blk_q[hit_q]    <= '0;
				for (int p = 1; p < ENTRIES; p++) begin
					if (p <= int'(pos)) begin
						order_q[p] <= order_q[p-1];
					end
				end
				order_q[0] <= hit_q;
			end
			if (op_back) begin
				for (int p = 0; p < ENTRIES - 1; p++) begin
					if (p >= int'(pos)) begin
						order_q[p] <= order_q[p+1];
					end
				end
				order_q[ENTRIES-1] <= hit_q;
			end
			if (op_upd) begin
				dirty_q[hit_q]  <= sd_q;
				logged_q[hit_q] <= sl_q;
				pins_q[hit_q]   <= pnew;
			end
			if (op_wbclr) begin
				dirty_q[hit_q]  <= 1'b0;
				logged_q[hit_q] <= 1'b0;
			end
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.status       = ost_q;
	assign rsp.slot         = oslot_q;
	assign rsp.entry_device = odev_q;
	assign rsp.entry_block  = oblk_q;
	assign rsp.enough       = oen_q;
	assign rsp.last         = olast_q;
endmodule

@@ hw/rtl/lbcs_seq_unit.sv @@
`timescale 1ns / 1ps
module lbcs_seq_unit (
	input  logic [lbcs_pkg::SEQ_W-1:0] a,
	input  logic [lbcs_pkg::SEQ_W-1:0] b,
	output logic                       le
);
	logic [lbcs_pkg::SEQ_W-1:0] d;

	// wraparound a <= b
	assign d  = a - b;
	assign le = (d == '0) || d[lbcs_pkg::SEQ_W-1];
endmodule

@@ hw/rtl/lbcs_checker.sv @@
`timescale 1ns / 1ps
module lbcs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic [lbcs_pkg::ACT_W-1:0]      req_action,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [lbcs_pkg::ST_W-1:0]       rsp_status,
	input logic                            rsp_enough,
	input logic                            rsp_last
);
	// busy after taking a real request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_action != lbcs_pkg::ACT_UNUSED) |=> !req_ready)
		else $error("ready right after a request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == lbcs_pkg::ST_WRITEBACK) |-> !rsp_last)
		else $error("writeback marked last");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != lbcs_pkg::ST_WRITEBACK) |-> rsp_last)
		else $error("closing result not marked last");

	a_enough_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_enough |-> (rsp_status == lbcs_pkg::ST_DONE))
		else $error("enough set outside a count result");
endmodule

bind lru_buffer_cache_slots_unit lbcs_checker u_lbcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_action(req.action),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_status(rsp.status),
	.rsp_enough(rsp.enough),
	.rsp_last  (rsp.last)
);

@@ test/lru_buffer_cache_slots_unit_tb.sv @@
`timescale 1ns / 1ps
module lru_buffer_cache_slots_unit_tb;

	localparam int NSLOT = lbcs_pkg::ENTRIES_DEF;

	typedef struct packed {
		logic [lbcs_pkg::ST_W-1:0]   status;
		logic [lbcs_pkg::SLOT_W-1:0] slot;
		logic [lbcs_pkg::DEV_W-1:0]  entry_device;
		logic [lbcs_pkg::BLK_W-1:0]  entry_block;
		logic                        enough;
		logic                        last;
	} cache_result_t;

	logic clk;
	logic arst_n;
	lbcs_req_if req();
	lbcs_rsp_if rsp();

	lru_buffer_cache_slots_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic                         c_valid [NSLOT];
	logic [lbcs_pkg::DEV_W-1:0]   c_device [NSLOT];
	logic [lbcs_pkg::BLK_W-1:0]   c_block [NSLOT];
	logic                         c_dirty [NSLOT];
	logic                         c_logged [NSLOT];
	logic [lbcs_pkg::SEQ_W-1:0]   c_seq [NSLOT];
	logic [lbcs_pkg::PIN_W-1:0]   c_pins [NSLOT];
	int                           c_order [NSLOT];

	cache_result_t pending_results[$];
	int  error_count;
	int  results_seen;
	int  requests_sent;
	int  hold_off_cycles;
	int  writebacks_seen;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic seq_at_or_before(logic [lbcs_pkg::SEQ_W-1:0] a,
		logic [lbcs_pkg::SEQ_W-1:0] b);
		logic [lbcs_pkg::SEQ_W-1:0] d;
		d = a - b;
		return (d == '0) || d[lbcs_pkg::SEQ_W-1];
	endfunction

	function automatic logic slot_reusable(int s, logic [lbcs_pkg::SEQ_W-1:0] committed);
		if (c_pins[s] != '0)
			return 1'b0;
		if (!c_logged[s])
			return 1'b1;
		return seq_at_or_before(c_seq[s], committed);
	endfunction

	function automatic int find_entry(logic [lbcs_pkg::DEV_W-1:0] dev,
		logic [lbcs_pkg::BLK_W-1:0] blk);
		for (int s = 0; s < NSLOT; s++)
			if (c_valid[s] && c_device[s] == dev && c_block[s] == blk)
				return s;
		return -1;
	endfunction

	function automatic int order_pos(int s);
		for (int p = 0; p < NSLOT; p++)
			if (c_order[p] == s)
				return p;
		return 0;
	endfunction

	function automatic void make_recent(int s);
		for (int p = order_pos(s); p + 1 < NSLOT; p++)
			c_order[p] = c_order[p + 1];
		c_order[NSLOT - 1] = s;
	endfunction

	function automatic void make_oldest(int s);
		for (int p = order_pos(s); p > 0; p--)
			c_order[p] = c_order[p - 1];
		c_order[0] = s;
	endfunction

	function automatic void drop_entry(int s);
		c_valid[s] = 1'b0;
		c_dirty[s] = 1'b0;
		c_logged[s] = 1'b0;
		c_device[s] = '0;
		c_block[s] = '0;
		make_oldest(s);
	endfunction

	function automatic int lowest_key(bit seen [NSLOT], bit one_dev,
		logic [lbcs_pkg::DEV_W-1:0] dev);
		int best;
		logic [19:0] best_key;
		logic [19:0] k;
		best = -1;
		best_key = '0;
		for (int s = 0; s < NSLOT; s++) begin
			if (!c_valid[s] || seen[s])
				continue;
			if (one_dev && c_device[s] != dev)
				continue;
			k = {c_device[s], c_block[s]};
			if (best < 0 || k < best_key) begin
				best = s;
				best_key = k;
			end
		end
		return best;
	endfunction

	function automatic void add_result(logic [lbcs_pkg::ST_W-1:0] st, int s,
		logic [lbcs_pkg::DEV_W-1:0] dev, logic [lbcs_pkg::BLK_W-1:0] blk, logic en, logic lst);
		cache_result_t r;
		r.status = st;
		r.slot = s[lbcs_pkg::SLOT_W-1:0];
		r.entry_device = dev;
		r.entry_block = blk;
		r.enough = en;
		r.last = lst;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void predict_flush(bit one_dev, logic [lbcs_pkg::DEV_W-1:0] dev,
		logic [lbcs_pkg::SEQ_W-1:0] committed);
		bit seen [NSLOT];
		int s;
		foreach (seen[i])
			seen[i] = 1'b0;
		s = lowest_key(seen, one_dev, dev);
		while (s >= 0) begin
			seen[s] = 1'b1;
			if (c_dirty[s] && (!c_logged[s] || seq_at_or_before(c_seq[s], committed))) begin
				add_result(lbcs_pkg::ST_WRITEBACK, s, c_device[s], c_block[s], 1'b0, 1'b0);
				c_dirty[s] = 1'b0;
				c_logged[s] = 1'b0;
			end
			s = lowest_key(seen, one_dev, dev);
		end
		add_result(lbcs_pkg::ST_DONE, 0, one_dev ? dev : '0, '0, 1'b0, 1'b1);
	endfunction

	function automatic void predict_request(logic [lbcs_pkg::ACT_W-1:0] act,
		logic [lbcs_pkg::DEV_W-1:0] dev, logic [lbcs_pkg::BLK_W-1:0] blk,
		logic [lbcs_pkg::SEQ_W-1:0] committed, logic [lbcs_pkg::WANT_W-1:0] want,
		logic sd, logic sl, logic [lbcs_pkg::SEQ_W-1:0] lseq, logic signed [1:0] pc);
		int hit;
		int s;
		int n;
		int pins;
		bit seen [NSLOT];
		bit placed;
		case (act)
			lbcs_pkg::ACT_LOOKUP: begin
				hit = find_entry(dev, blk);
				if (int'(dev) >= lbcs_pkg::DEVICES_DEF) begin
					add_result(lbcs_pkg::ST_NO_SLOT, 0, dev, blk, 1'b0, 1'b1);
				end else if (hit >= 0) begin
					make_recent(hit);
					add_result(lbcs_pkg::ST_HIT, hit, dev, blk, 1'b0, 1'b1);
				end else begin
					placed = 1'b0;
					for (int p = 0; p < NSLOT && !placed; p++) begin
						s = c_order[p];
						if (c_valid[s]) begin
							if (!slot_reusable(s, committed))
								continue;
							if (c_dirty[s])
								add_result(lbcs_pkg::ST_WRITEBACK, s, c_device[s], c_block[s],
									1'b0, 1'b0);
						end
						c_valid[s] = 1'b1;
						c_dirty[s] = 1'b0;
						c_logged[s] = 1'b0;
						c_device[s] = dev;
						c_block[s] = blk;
						make_recent(s);
						add_result(lbcs_pkg::ST_MISS, s, dev, blk, 1'b0, 1'b1);
						placed = 1'b1;
					end
					if (!placed)
						add_result(lbcs_pkg::ST_NO_SLOT, 0, dev, blk, 1'b0, 1'b1);
				end
			end
			lbcs_pkg::ACT_FREE: begin
				hit = find_entry(dev, blk);
				if (hit >= 0) begin
					drop_entry(hit);
					add_result(lbcs_pkg::ST_DONE, hit, dev, blk, 1'b0, 1'b1);
				end else begin
					add_result(lbcs_pkg::ST_NOT_FOUND, 0, dev, blk, 1'b0, 1'b1);
				end
			end
			lbcs_pkg::ACT_INVAL: begin
				foreach (seen[i])
					seen[i] = 1'b0;
				s = lowest_key(seen, 1'b1, dev);
				while (s >= 0) begin
					drop_entry(s);
					s = lowest_key(seen, 1'b1, dev);
				end
				add_result(lbcs_pkg::ST_DONE, 0, dev, '0, 1'b0, 1'b1);
			end
			lbcs_pkg::ACT_FLUSH_DEV: predict_flush(1'b1, dev, committed);
			lbcs_pkg::ACT_FLUSH_ALL: predict_flush(1'b0, '0, committed);
			lbcs_pkg::ACT_COUNT: begin
				n = want;
				for (int p = 0; p < NSLOT && n > 0; p++) begin
					s = c_order[p];
					if (!c_valid[s] || slot_reusable(s, committed))
						n--;
				end
				add_result(lbcs_pkg::ST_DONE, 0, dev, '0, n == 0, 1'b1);
			end
			lbcs_pkg::ACT_UPDATE: begin
				hit = find_entry(dev, blk);
				if (hit >= 0) begin
					c_dirty[hit] = sd;
					c_logged[hit] = sl;
					c_seq[hit] = lseq;
					pins = int'(c_pins[hit]) + int'(pc);
					if (pins < 0)
						pins = 0;
					if (pins > 255)
						pins = 255;
					c_pins[hit] = pins[lbcs_pkg::PIN_W-1:0];
					add_result(lbcs_pkg::ST_DONE, hit, dev, blk, 1'b0, 1'b1);
				end else begin
					add_result(lbcs_pkg::ST_NOT_FOUND, 0, dev, blk, 1'b0, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_request(logic [lbcs_pkg::ACT_W-1:0] act,
		logic [lbcs_pkg::DEV_W-1:0] dev, logic [lbcs_pkg::BLK_W-1:0] blk,
		logic [lbcs_pkg::SEQ_W-1:0] committed, logic [lbcs_pkg::WANT_W-1:0] want,
		logic sd, logic sl, logic [lbcs_pkg::SEQ_W-1:0] lseq, logic signed [1:0] pc);
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.device <= dev;
		req.block_id <= blk;
		req.committed_seq <= committed;
		req.want <= want;
		req.set_dirty <= sd;
		req.set_logged <= sl;
		req.log_seq <= lseq;
		req.pin_change <= pc;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predict_request(act, dev, blk, committed, want, sd, sl, lseq, pc);
		requests_sent++;
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				rsp.ready <= 1'b0;
				hold_off_cycles--;
			end else if ($urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b1;
			end else begin
				stall = $urandom_range(0, 12);
				if (stall == 0) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready <= 1'b0;
					repeat (stall) @(posedge clk);
					rsp.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cache_result_t want_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			results_seen++;
			if (rsp.status == lbcs_pkg::ST_WRITEBACK)
				writebacks_seen++;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: status %0d", rsp.status);
				error_count++;
			end else begin
				want_r = pending_results.pop_front();
				if (rsp.status !== want_r.status) begin
					$error("status expected %0d got %0d", want_r.status, rsp.status);
					error_count++;
				end
				if (rsp.slot !== want_r.slot) begin
					$error("slot expected %0d got %0d", want_r.slot, rsp.slot);
					error_count++;
				end
				if (rsp.entry_device !== want_r.entry_device) begin
					$error("entry_device expected %0d got %0d", want_r.entry_device,
						rsp.entry_device);
					error_count++;
				end
				if (rsp.entry_block !== want_r.entry_block) begin
					$error("entry_block expected %0h got %0h", want_r.entry_block,
						rsp.entry_block);
					error_count++;
				end
				if (rsp.enough !== want_r.enough) begin
					$error("enough expected %0d got %0d", want_r.enough, rsp.enough);
					error_count++;
				end
				if (rsp.last !== want_r.last) begin
					$error("last expected %0d got %0d", want_r.last, rsp.last);
					error_count++;
				end
			end
		end
	end

	function automatic logic [lbcs_pkg::BLK_W-1:0] pick_block();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return lbcs_pkg::BLK_W'($urandom_range(0, 5));
		endcase
	endfunction

	function automatic logic [lbcs_pkg::DEV_W-1:0] pick_device();
		if ($urandom_range(0, 5) == 0)
			return lbcs_pkg::DEV_W'($urandom);
		return lbcs_pkg::DEV_W'($urandom_range(0, 2));
	endfunction

	function automatic logic [lbcs_pkg::SEQ_W-1:0] near_seq(logic [lbcs_pkg::SEQ_W-1:0] base);
		case ($urandom_range(0, 3))
			0: return base;
			1: return base + lbcs_pkg::SEQ_W'($urandom_range(1, 4));
			2: return base - lbcs_pkg::SEQ_W'($urandom_range(1, 4));
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed_basics();
		send_request(lbcs_pkg::ACT_COUNT, 4'd0, '0, '0, 5'd0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_COUNT, 4'd15, '0, '0, 5'd16, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_COUNT, 4'd1, '0, '0, 5'd31, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_LOOKUP, 4'd0, 16'h0000, '0, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_LOOKUP, 4'd15, 16'hffff, '1, '1, 1, 1, '1, -2'sd1);
		send_request(lbcs_pkg::ACT_LOOKUP, 4'd0, 16'h0000, '0, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_UPDATE, 4'd0, 16'h0000, '0, '0, 1, 1, 32'hffff_fffe, 2'sd1);
		send_request(lbcs_pkg::ACT_UPDATE, 4'd3, 16'h1234, '0, '0, 1, 0, '0, 2'sd1);
		send_request(lbcs_pkg::ACT_FREE, 4'd3, 16'h1234, '0, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_UPDATE, 4'd0, 16'h0000, '0, '0, 1, 1, 32'hffff_fffe,
			-2'sd2);
		send_request(lbcs_pkg::ACT_FLUSH_DEV, 4'd0, '0, 32'h8000_0000, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_FLUSH_DEV, 4'd0, '0, 32'hffff_ffff, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_UPDATE, 4'd15, 16'hffff, '0, '0, 1, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_FLUSH_ALL, 4'd7, '0, '0, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_UNUSED, 4'd2, 16'h5555, '1, '1, 1, 1, '1, -2'sd1);
		send_request(lbcs_pkg::ACT_UPDATE, 4'd15, 16'hffff, '0, '0, 1, 0, '0, -2'sd1);
		send_request(lbcs_pkg::ACT_INVAL, 4'd15, '0, '0, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_FREE, 4'd15, 16'hffff, '0, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_FREE, 4'd0, 16'h0000, '0, '0, 0, 0, '0, 2'sd0);
		wait_drained();
	endtask

	task automatic test_pinned_full();
		for (int i = 0; i < NSLOT; i++) begin
			send_request(lbcs_pkg::ACT_LOOKUP, 4'd5, lbcs_pkg::BLK_W'(i), '0, '0, 0, 0, '0,
				2'sd0);
			send_request(lbcs_pkg::ACT_UPDATE, 4'd5, lbcs_pkg::BLK_W'(i), '0, '0, 1, 0, '0,
				2'sd1);
		end
		send_request(lbcs_pkg::ACT_LOOKUP, 4'd6, 16'h0042, '0, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_COUNT, 4'd6, '0, '0, 5'd1, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_FLUSH_ALL, 4'd0, '0, '0, '0, 0, 0, '0, 2'sd0);
		send_request(lbcs_pkg::ACT_INVAL, 4'd5, '0, '0, '0, 0, 0, '0, 2'sd0);
		wait_drained();
	endtask

	task automatic test_random_traffic(int count);
		logic [lbcs_pkg::ACT_W-1:0] act;
		logic [lbcs_pkg::SEQ_W-1:0] base;
		logic [lbcs_pkg::DEV_W-1:0] dev;
		logic [lbcs_pkg::BLK_W-1:0] blk;
		int roll;
		base = $urandom;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 40) act = lbcs_pkg::ACT_LOOKUP;
			else if (roll < 65) act = lbcs_pkg::ACT_UPDATE;
			else if (roll < 72) act = lbcs_pkg::ACT_FREE;
			else if (roll < 76) act = lbcs_pkg::ACT_INVAL;
			else if (roll < 84) act = lbcs_pkg::ACT_FLUSH_DEV;
			else if (roll < 88) act = lbcs_pkg::ACT_FLUSH_ALL;
			else if (roll < 97) act = lbcs_pkg::ACT_COUNT;
			else act = lbcs_pkg::ACT_UNUSED;
			if (i == count / 2)
				hold_off_cycles = 600;
			dev = pick_device();
			blk = pick_block();
			if ($urandom_range(0, 9) == 0)
				base = $urandom;
			send_request(act, dev, blk, near_seq(base),
				lbcs_pkg::WANT_W'($urandom_range(0, 17)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), near_seq(base),
				2'($urandom_range(0, 3)));
		end
		wait_drained();
	endtask

	initial begin
		req.valid = 1'b0;
		req.action = lbcs_pkg::ACT_LOOKUP;
		req.device = '0;
		req.block_id = '0;
		req.committed_seq = '0;
		req.want = '0;
		req.set_dirty = 1'b0;
		req.set_logged = 1'b0;
		req.log_seq = '0;
		req.pin_change = 2'sd0;
		error_count = 0;
		results_seen = 0;
		requests_sent = 0;
		hold_off_cycles = 0;
		writebacks_seen = 0;
		for (int s = 0; s < NSLOT; s++) begin
			c_valid[s] = 1'b0;
			c_device[s] = '0;
			c_block[s] = '0;
			c_dirty[s] = 1'b0;
			c_logged[s] = 1'b0;
			c_seq[s] = '0;
			c_pins[s] = '0;
			c_order[s] = s;
		end
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_basics();
		test_pinned_full();
		test_random_traffic(300);
		$display("requests sent %0d, results checked %0d, writebacks %0d", requests_sent,
			results_seen, writebacks_seen);
		if (error_count == 0 && pending_results.size() == 0)
			$display("lru_buffer_cache_slots_unit_tb: clean");
		else
			$display("lru_buffer_cache_slots_unit_tb: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("lru_buffer_cache_slots_unit_tb: errors");
		$finish;
	end

endmodule
